[src/lfu_pkg.sv]
`timescale 1ns / 1ps
// lfu_pkg: shared field widths, opcodes and constants for the LFU cache.
// No dependencies; lfu_if and the top module import it.
package lfu_pkg;

    localparam int KEY_W = 32;
    localparam int VAL_W = 32;
    localparam int CNT_W = 32;
    localparam int CAP_W = 5;

    // request opcodes
    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
    localparam logic [VAL_W-1:0] NO_VALUE  = '1;   // -1
    localparam logic [CNT_W-1:0] COUNT_MAX = '1;
    localparam logic [CNT_W-1:0] COUNT_ONE = 32'd1;

endpackage

[src/lfu_if.sv]
`timescale 1ns / 1ps
// lfu_if: valid/ready channel interfaces for requests, responses and the
// capacity register write port. Depends on lfu_pkg.

interface lfu_req_if import lfu_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic                    op;
    logic signed [KEY_W-1:0] key;
    logic signed [VAL_W-1:0] value;

    modport source (output valid, output op, output key, output value, input ready);
    modport sink   (input valid, input op, input key, input value, output ready);
endinterface

interface lfu_rsp_if import lfu_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic                    found;
    logic signed [VAL_W-1:0] read_value;
    logic                    evicted;

    modport source (output valid, output found, output read_value, output evicted,
                    input ready);
    modport sink   (input valid, input found, input read_value, input evicted,
                    output ready);
endinterface

interface lfu_cfg_if import lfu_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CAP_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[src/lfu_ram.sv]
`timescale 1ns / 1ps
// lfu_ram: generic simple dual-port RAM, one write and one registered read
// port. No dependencies.
module lfu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[src/lfu_cache_lru_tiebreak_top.sv]
`timescale 1ns / 1ps
// lfu_cache_lru_tiebreak_top: fully associative LFU key/value cache with
// LRU tie-break. Depends on lfu_pkg, lfu_if and lfu_ram.
//
// Usage
//   req : get (op 0) or put (op 1) request with key and value.
//   rsp : one response per request - found, read_value (-1 unless get hit),
//         evicted.
//   cfg : single write port for the capacity register (reset 16, values
//         above ENTRIES act as ENTRIES, 0 blocks all puts). Write only while
//         the cache is idle; the port is always ready.
// Operation
//   A request is served in two passes over the entry RAMs: a scan pass reads
//   every slot once for key match, victim and free slot, then a rank pass
//   rewrites the recency ranks, one slot per cycle. Get misses and puts at
//   capacity zero skip the rank pass. One request in flight; the next is
//   taken only once the cache returns to idle.
// Reset
//   Clears the valid bits and occupancy; no clearing pass is needed, the RAMs
//   are only read for valid slots. req.ready is high as soon as reset ends.
// Back-pressure
//   The response sits in an output register, so the next request is taken
//   while rsp.ready is low; a finished request then waits until the output
//   register frees up.
module lfu_cache_lru_tiebreak_top import lfu_pkg::*; #(
    parameter int ENTRIES = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    lfu_cfg_if.sink    cfg,
    lfu_req_if.sink    req,
    lfu_rsp_if.source  rsp
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OW = $clog2(ENTRIES + 1);
    localparam int DW = KEY_W + VAL_W + CNT_W;
    localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_RANK,
        ST_FINISH
    } state_t;

    state_t state_reg;

    // configuration and occupancy
    logic [CAP_W-1:0]   capacity_reg;
    logic [ENTRIES-1:0] valid_reg;
    logic [OW-1:0]      occ_reg;
    logic [OW-1:0]      cap_eff;

    // latched request
    logic             op_reg;
    logic [KEY_W-1:0] key_reg;
    logic [VAL_W-1:0] val_reg;

    // RAM read sequencing: rd_* issues, chk_* marks data arriving
    logic [IW-1:0] rd_idx_reg;
    logic          rd_busy_reg;
    logic          chk_vld_reg;
    logic [IW-1:0] chk_idx_reg;

    // scan results
    logic             hit_found_reg;
    logic [IW-1:0]    hit_idx_reg;
    logic [VAL_W-1:0] hit_val_reg;
    logic [CNT_W-1:0] hit_cnt_reg;
    logic [IW-1:0]    hit_rank_reg;
    logic             vic_found_reg;
    logic [IW-1:0]    vic_idx_reg;
    logic [CNT_W-1:0] vic_cnt_reg;
    logic [IW-1:0]    vic_rank_reg;
    logic             free_found_reg;
    logic [IW-1:0]    free_idx_reg;

    // rank pass control
    logic [IW-1:0] tgt_reg;
    logic [IW-1:0] lim_reg;
    logic          all_reg;

    // pending and delivered response
    logic             res_found_reg;
    logic [VAL_W-1:0] res_read_reg;
    logic             res_ev_reg;
    logic             out_valid_reg;
    logic             out_found_reg;
    logic [VAL_W-1:0] out_read_reg;
    logic             out_ev_reg;

    // RAM ports
    logic          data_we;
    logic [IW-1:0] data_waddr;
    logic [DW-1:0] data_wdata;
    logic [DW-1:0] data_rdata;
    logic          rank_we;
    logic [IW-1:0] rank_wdata;
    logic [IW-1:0] rank_rdata;

    // slot fields as read back
    logic [KEY_W-1:0] rd_key;
    logic [VAL_W-1:0] rd_val;
    logic [CNT_W-1:0] rd_cnt;
    logic             rd_slot_valid;
    logic             scan_match;
    logic             scan_better;

    // decision
    logic             is_put;
    logic             dec_act;
    logic [IW-1:0]    dec_tgt;
    logic [IW-1:0]    dec_lim;
    logic             dec_all;
    logic             dec_ins;
    logic             dec_ev;
    logic [VAL_W-1:0] dec_val;
    logic [CNT_W-1:0] dec_cnt;
    logic             req_fire;
    logic             rsp_free;

    // -----------------------------------------------------------------
    // Entry storage: {key, value, count} in one RAM, recency rank in another
    // -----------------------------------------------------------------
    lfu_ram #(
        .WIDTH (DW),
        .DEPTH (ENTRIES)
    ) u_data_ram (
        .clk   (clk),
        .we    (data_we),
        .waddr (data_waddr),
        .wdata (data_wdata),
        .raddr (rd_idx_reg),
        .rdata (data_rdata)
    );

    lfu_ram #(
        .WIDTH (IW),
        .DEPTH (ENTRIES)
    ) u_rank_ram (
        .clk   (clk),
        .we    (rank_we),
        .waddr (chk_idx_reg),
        .wdata (rank_wdata),
        .raddr (rd_idx_reg),
        .rdata (rank_rdata)
    );

    assign cfg.ready = 1'b1;
    assign req.ready = (state_reg == ST_IDLE);
    assign req_fire  = req.valid && (state_reg == ST_IDLE);
    assign rsp_free  = !out_valid_reg || rsp.ready;

    assign rsp.valid      = out_valid_reg;
    assign rsp.found      = out_found_reg;
    assign rsp.read_value = out_read_reg;
    assign rsp.evicted    = out_ev_reg;

    assign cap_eff = (32'(capacity_reg) > 32'(ENTRIES)) ? OW'(ENTRIES)
                                                         : OW'(capacity_reg);

    assign rd_key        = data_rdata[DW-1 -: KEY_W];
    assign rd_val        = data_rdata[CNT_W +: VAL_W];
    assign rd_cnt        = data_rdata[CNT_W-1:0];
    assign rd_slot_valid = valid_reg[chk_idx_reg];

    assign scan_match  = rd_slot_valid && (rd_key == key_reg);
    assign scan_better = rd_slot_valid &&
                         (!vic_found_reg || (rd_cnt < vic_cnt_reg) ||
                          ((rd_cnt == vic_cnt_reg) && (rank_rdata > vic_rank_reg)));

    // what the request does, settled once the scan is complete
    always_comb
    begin
        is_put  = (op_reg == OP_PUT);
        dec_act = 1'b0;
        dec_tgt = hit_idx_reg;
        dec_lim = hit_rank_reg;
        dec_all = 1'b0;
        dec_ins = 1'b0;
        dec_ev  = 1'b0;
        dec_val = is_put ? val_reg : hit_val_reg;
        dec_cnt = (hit_cnt_reg == COUNT_MAX) ? hit_cnt_reg : hit_cnt_reg + 1'b1;
        if (hit_found_reg && (!is_put || (cap_eff != '0)))
        begin
            dec_act = 1'b1;     // hit: bump count, move to newest
        end
        else if (is_put && (cap_eff != '0) && !hit_found_reg)
        begin
            dec_val = val_reg;
            dec_cnt = COUNT_ONE;
            if (occ_reg >= cap_eff)
            begin
                dec_act = vic_found_reg;
                dec_ev  = vic_found_reg;
                dec_tgt = vic_idx_reg;
                dec_lim = vic_rank_reg;
            end
            else
            begin
                dec_act = free_found_reg;
                dec_ins = free_found_reg;
                dec_all = 1'b1;
                dec_tgt = free_idx_reg;
            end
        end
    end

    assign data_we    = (state_reg == ST_DECIDE) && dec_act;
    assign data_waddr = dec_tgt;
    assign data_wdata = {key_reg, dec_val, dec_cnt};

    // rank pass: target becomes newest; valid slots newer than it (all valid slots on an insert) age by one
    always_comb
    begin
        rank_we    = 1'b0;
        rank_wdata = rank_rdata + 1'b1;
        if ((state_reg == ST_RANK) && chk_vld_reg)
        begin
            if (chk_idx_reg == tgt_reg)
            begin
                rank_we    = 1'b1;
                rank_wdata = '0;
            end
            else if (rd_slot_valid && (all_reg || (rank_rdata < lim_reg)))
            begin
                rank_we = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            capacity_reg   <= CAP_RESET;
            valid_reg      <= '0;
            occ_reg        <= '0;
            op_reg         <= OP_GET;
            key_reg        <= '0;
            val_reg        <= '0;
            rd_idx_reg     <= '0;
            rd_busy_reg    <= 1'b0;
            chk_vld_reg    <= 1'b0;
            chk_idx_reg    <= '0;
            hit_found_reg  <= 1'b0;
            hit_idx_reg    <= '0;
            hit_val_reg    <= '0;
            hit_cnt_reg    <= '0;
            hit_rank_reg   <= '0;
            vic_found_reg  <= 1'b0;
            vic_idx_reg    <= '0;
            vic_cnt_reg    <= '0;
            vic_rank_reg   <= '0;
            free_found_reg <= 1'b0;
            free_idx_reg   <= '0;
            tgt_reg        <= '0;
            lim_reg        <= '0;
            all_reg        <= 1'b0;
            res_found_reg  <= 1'b0;
            res_read_reg   <= '0;
            res_ev_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_found_reg  <= 1'b0;
            out_read_reg   <= '0;
            out_ev_reg     <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                capacity_reg <= cfg.data;
            end

            if (out_valid_reg && rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            // read address sequencer
            chk_vld_reg <= rd_busy_reg;
            chk_idx_reg <= rd_idx_reg;
            if (rd_busy_reg)
            begin
                if (rd_idx_reg == LAST)
                begin
                    rd_busy_reg <= 1'b0;
                end
                else
                begin
                    rd_idx_reg <= rd_idx_reg + 1'b1;
                end
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (req_fire)
                    begin
                        op_reg         <= req.op;
                        key_reg        <= req.key;
                        val_reg        <= req.value;
                        hit_found_reg  <= 1'b0;
                        vic_found_reg  <= 1'b0;
                        free_found_reg <= 1'b0;
                        rd_idx_reg     <= '0;
                        rd_busy_reg    <= 1'b1;
                        state_reg      <= ST_SCAN;
                    end
                end

                ST_SCAN:
                begin
                    if (chk_vld_reg)
                    begin
                        if (scan_match && !hit_found_reg)
                        begin
                            hit_found_reg <= 1'b1;
                            hit_idx_reg   <= chk_idx_reg;
                            hit_val_reg   <= rd_val;
                            hit_cnt_reg   <= rd_cnt;
                            hit_rank_reg  <= rank_rdata;
                        end
                        if (scan_better)
                        begin
                            vic_found_reg <= 1'b1;
                            vic_idx_reg   <= chk_idx_reg;
                            vic_cnt_reg   <= rd_cnt;
                            vic_rank_reg  <= rank_rdata;
                        end
                        if (!rd_slot_valid && !free_found_reg)
                        begin
                            free_found_reg <= 1'b1;
                            free_idx_reg   <= chk_idx_reg;
                        end
                        if (chk_idx_reg == LAST)
                        begin
                            state_reg <= ST_DECIDE;
                        end
                    end
                end

                ST_DECIDE:
                begin
                    res_found_reg <= hit_found_reg;
                    res_read_reg  <= (!is_put && hit_found_reg) ? hit_val_reg : NO_VALUE;
                    res_ev_reg    <= dec_ev;
                    tgt_reg       <= dec_tgt;
                    lim_reg       <= dec_lim;
                    all_reg       <= dec_all;
                    if (dec_ins)
                    begin
                        valid_reg[dec_tgt] <= 1'b1;
                        occ_reg            <= occ_reg + 1'b1;
                    end
                    if (dec_act)
                    begin
                        rd_idx_reg  <= '0;
                        rd_busy_reg <= 1'b1;
                        state_reg   <= ST_RANK;
                    end
                    else
                    begin
                        state_reg <= ST_FINISH;
                    end
                end

                ST_RANK:
                begin
                    if (chk_vld_reg && (chk_idx_reg == LAST))
                    begin
                        state_reg <= ST_FINISH;
                    end
                end

                ST_FINISH:
                begin
                    if (rsp_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_found_reg <= res_found_reg;
                        out_read_reg  <= res_read_reg;
                        out_ev_reg    <= res_ev_reg;
                        state_reg     <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
